>>> sv/dmzh_pkg.sv
// ----------------------------------------------------------------------------
// dmzh_pkg
// Shared types and constants for the dual motor zero homing core.
// ----------------------------------------------------------------------------
package dmzh_pkg;

    localparam int AngleW = 32;
    localparam int RefW   = 16;
    localparam int LimW   = 8;
    localparam int CfgW   = 16;

    // register indexes on the config port
    localparam logic CFG_DEBOUNCE_LIMIT = 1'b0;
    localparam logic CFG_SEARCH_SPEED   = 1'b1;

    // register reset values
    localparam logic [LimW-1:0]        DEBOUNCE_LIMIT_RST = 8'd5;
    localparam logic signed [RefW-1:0] SEARCH_SPEED_RST   = 16'sd1000;

    // input command codes
    typedef enum logic {
        CMD_INIT = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    // per-channel homing phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_RUNNING = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    // one transfer into a channel
    typedef struct packed {
        logic              accept;
        cmd_t              cmd;
        logic              sw;
        logic [AngleW-1:0] angle;
    } chan_in_t;

    // one channel's result; ref_write sits in the lowest bit
    typedef struct packed {
        logic                     done;
        logic signed [AngleW-1:0] zero;
        logic signed [RefW-1:0]   ref_val;
        logic                     ref_write;
    } chan_res_t;

endpackage

>>> sv/dmzh_chan.sv
// ----------------------------------------------------------------------------
// dmzh_chan
// One homing channel: issues the search speed, debounces the index switch
// and captures the motor angle once the settled level flips.
// ----------------------------------------------------------------------------
module dmzh_chan (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dmzh_pkg::chan_in_t                  in_i,
    input  logic [dmzh_pkg::LimW-1:0]           debounce_limit,
    input  logic signed [dmzh_pkg::RefW-1:0]    search_speed,
    output dmzh_pkg::chan_res_t                 res_o
);
    import dmzh_pkg::*;

    phase_t              phase_reg,   phase_next;
    logic                cand_reg,    cand_next;
    logic                settled_reg, settled_next;
    logic [LimW-1:0]     count_reg,   count_next;
    logic [AngleW-1:0]   zero_reg,    zero_next;

    logic                run_cand;
    logic [LimW-1:0]     run_count;

    // next state and result for this transfer
    always_comb begin
        phase_next      = phase_reg;
        cand_next       = cand_reg;
        settled_next    = settled_reg;
        count_next      = count_reg;
        zero_next       = zero_reg;
        run_cand        = cand_reg;
        run_count       = count_reg;
        res_o.ref_write = 1'b0;
        res_o.ref_val   = '0;

        if (in_i.cmd == CMD_INIT) begin
            // latch switch level as settled, back to idle
            settled_next = in_i.sw;
            cand_next    = in_i.sw;
            phase_next   = PH_IDLE;
            count_next   = '0;
            zero_next    = '0;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    res_o.ref_write = 1'b1;
                    res_o.ref_val   = search_speed;
                    phase_next      = PH_RUNNING;
                    count_next      = '0;
                end
                PH_RUNNING: begin
                    // saturating steady count, restart on a level change
                    if (in_i.sw == cand_reg) begin
                        if (count_reg < debounce_limit) begin
                            run_count = count_reg + LimW'(1);
                        end
                    end else begin
                        run_cand  = in_i.sw;
                        run_count = '0;
                    end
                    if (run_count >= debounce_limit && run_cand != settled_reg) begin
                        res_o.ref_write = 1'b1;
                        zero_next       = in_i.angle;
                        phase_next      = PH_DONE;
                        settled_next    = run_cand;
                        cand_next       = run_cand;
                        count_next      = '0;
                    end else begin
                        cand_next  = run_cand;
                        count_next = run_count;
                    end
                end
                default: ;  // done holds
            endcase
        end

        res_o.zero = zero_next;
        res_o.done = (phase_next != PH_IDLE) && (phase_next != PH_RUNNING);
    end

    // channel state, updated on each accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cand_reg    <= 1'b0;
            settled_reg <= 1'b0;
            count_reg   <= '0;
            zero_reg    <= '0;
        end else if (in_i.accept) begin
            phase_reg   <= phase_next;
            cand_reg    <= cand_next;
            settled_reg <= settled_next;
            count_reg   <= count_next;
            zero_reg    <= zero_next;
        end
    end

    // a finishing tick always issues a zero reference
    a_finish_ref_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_i.accept && phase_reg == PH_RUNNING && phase_next == PH_DONE)
            |-> (res_o.ref_write && res_o.ref_val == '0))
        else $error("finish without zero reference");

    // a tick never leaves the done phase
    a_done_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_i.accept && in_i.cmd == CMD_TICK && phase_reg == PH_DONE)
            |=> (phase_reg == PH_DONE && $stable(zero_reg)))
        else $error("done channel changed on a tick");

    // steady count never passes the debounce limit while running
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_i.accept && $stable(debounce_limit) && phase_reg == PH_RUNNING
            && count_reg <= debounce_limit) |-> (count_next <= debounce_limit))
        else $error("steady count overran the limit");

endmodule

>>> sv/dual_motor_zero_homing_core.sv
// ----------------------------------------------------------------------------
// dual_motor_zero_homing_core
// Homes two motors against debounced index switches.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transfer per control step. s_tuser carries the
//   command (init or tick); s_tdata carries both switch levels and angles.
//   An init latches each switch level as settled and resets both channels;
//   a tick runs one control step of each channel.
//   Output stream (m_*): exactly one result transfer per input transfer,
//   with speed reference writes, captured zero angles and done flags.
//   Config port: cfg_wr_en writes cfg_wdata to the register at cfg_index
//   (0 debounce limit, 1 search speed) at the clock edge; no read-back.
// Output register and throughput:
//   The result is registered in the single output register on the input
//   transfer. One transfer per cycle is sustained while m_tready is high.
//   s_tready is high whenever the output register is empty or being taken,
//   so a stalled receiver holds the result and back-pressures the input.
// Reset:
//   aresetn (synchronous, active low) sets both channels idle with zero
//   captures, empties the output and restores limit 5 and speed 1000.
// ----------------------------------------------------------------------------
module dual_motor_zero_homing_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [71:0]                   s_tdata,  // left_switch, left_angle,
                                                    // right_switch, right_angle
    input  logic                          s_tuser,  // command
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [103:0]                  m_tdata,  // left_ref_write, left_ref,
                                                    // left_zero, left_done,
                                                    // right_ref_write, right_ref,
                                                    // right_zero, right_done,
                                                    // all_done
    // config write port
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [dmzh_pkg::CfgW-1:0]     cfg_wdata
);
    import dmzh_pkg::*;

    logic                     s_accept;
    chan_in_t                 left_in, right_in;
    chan_res_t                left_res, right_res;
    chan_res_t                left_res_reg, right_res_reg;
    logic                     all_done_reg;
    logic                     m_tvalid_reg;
    logic [LimW-1:0]          debounce_limit_reg;
    logic signed [RefW-1:0]   search_speed_reg;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = !m_tvalid_reg || m_tready;

    // unpack the input transfer per channel
    always_comb begin
        left_in.accept  = s_accept;
        left_in.cmd     = cmd_t'(s_tuser);
        left_in.sw      = s_tdata[0];
        left_in.angle   = s_tdata[32:1];
        right_in.accept = s_accept;
        right_in.cmd    = cmd_t'(s_tuser);
        right_in.sw     = s_tdata[33];
        right_in.angle  = s_tdata[65:34];
    end

    dmzh_chan u_left (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_i           (left_in),
        .debounce_limit (debounce_limit_reg),
        .search_speed   (search_speed_reg),
        .res_o          (left_res)
    );

    dmzh_chan u_right (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_i           (right_in),
        .debounce_limit (debounce_limit_reg),
        .search_speed   (search_speed_reg),
        .res_o          (right_res)
    );

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_limit_reg <= DEBOUNCE_LIMIT_RST;
            search_speed_reg   <= SEARCH_SPEED_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEBOUNCE_LIMIT: debounce_limit_reg <= cfg_wdata[LimW-1:0];
                CFG_SEARCH_SPEED:   search_speed_reg   <= cfg_wdata[RefW-1:0];
                default: ;
            endcase
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            left_res_reg  <= left_res;
            right_res_reg <= right_res;
            all_done_reg  <= left_res.done && right_res.done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, all_done_reg, right_res_reg, left_res_reg};

    // an init transfer yields a clean result with no writes or done flags
    a_init_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == CMD_INIT) |=>
            (m_tvalid && !left_res_reg.ref_write && !right_res_reg.ref_write
             && !left_res_reg.done && !right_res_reg.done && !all_done_reg
             && left_res_reg.zero == '0 && right_res_reg.zero == '0))
        else $error("init result not clean");

    // a reference write alongside done is the zero stop reference
    a_left_stop_ref: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && left_res_reg.ref_write && left_res_reg.done)
            |-> (left_res_reg.ref_val == '0))
        else $error("left stop reference not zero");

    a_right_stop_ref: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && right_res_reg.ref_write && right_res_reg.done)
            |-> (right_res_reg.ref_val == '0))
        else $error("right stop reference not zero");

endmodule
